>>> hdl/bemc_pkg.sv
package bemc_pkg;

	localparam int NUM_W  = 32;
	localparam int ADDR_W = 5;

	// item modes
	localparam logic [1:0] MODE_EDGE  = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_TOUCH = 2'd2;

	// message kinds
	localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
	localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
	localparam logic [1:0] KIND_CC       = 2'd2;
	localparam logic [1:0] KIND_BEND     = 2'd3;

	// bow direction codes
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_POS  = 2'd1;
	localparam logic [1:0] DIR_NEG  = 2'd3;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_NOTE  = 3'd0;
	localparam logic [2:0] REG_CTRL  = 3'd1;
	localparam logic [2:0] REG_VEL   = 3'd2;
	localparam logic [2:0] REG_CHAN  = 3'd3;
	localparam logic [2:0] REG_WIN   = 3'd4;
	localparam logic [2:0] REG_RUN   = 3'd5;
	localparam logic [2:0] REG_TOUCH = 3'd6;
	localparam logic [2:0] REG_MAX   = 3'd7;

	// 2 * 60000: numerator scale for round-half-up rpm
	localparam logic [16:0] RPM_K      = 17'd120000;
	localparam logic [9:0]  ADC_FULL   = 10'd1023;
	localparam logic [6:0]  MAP_FULL   = 7'd127;
	localparam int          BEND_SHIFT = 13;

	localparam logic signed [15:0] TICK_MAX = 16'sh7FFF;
	localparam logic signed [15:0] TICK_MIN = 16'sh8000;

	typedef struct packed {
		logic [6:0] note_number;
		logic [6:0] controller_number;
		logic [6:0] note_velocity;
		logic [4:0] midi_channel;
		logic [9:0] window_ms;
		logic [7:0] run_threshold;
		logic [9:0] touch_threshold;
		logic [9:0] max_rpm;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		note_number:       7'd64,
		controller_number: 7'd20,
		note_velocity:     7'd127,
		midi_channel:      5'd1,
		window_ms:         10'd100,
		run_threshold:     8'd10,
		touch_threshold:   10'd25,
		max_rpm:           10'd600
	};

	typedef struct packed {
		logic       take;
		logic       mul;
		logic       div_rpm;
		logic       div_map;
		logic       div_bend;
		logic       rpm_save;
		logic       map_save;
		logic       bend_save;
		logic       emit;
		logic [1:0] emit_kind;
		logic       emit_last;
	} cmd_t;

	typedef struct packed {
		logic win_end;
		logic touch;
		logic div_done;
		logic change;
		logic note_on;
		logic cc_due;
		logic out_free;
	} sts_t;

endpackage

>>> hdl/bemc_item_if.sv
interface bemc_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic       b_level;
	logic [9:0] sample;

	modport source (output valid, output mode, output b_level, output sample, input ready);
	modport sink   (input valid, input mode, input b_level, input sample, output ready);
endinterface

>>> hdl/bemc_msg_if.sv
interface bemc_msg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [6:0]  data_one;
	logic [6:0]  data_two;
	logic [13:0] bend;
	logic [4:0]  channel;
	logic        last;

	modport source (
		output valid, output kind, output data_one, output data_two,
		output bend, output channel, output last, input ready
	);
	modport sink (
		input valid, input kind, input data_one, input data_two,
		input bend, input channel, input last, output ready
	);
endinterface

>>> hdl/bemc_div.sv
module bemc_div #(
	parameter int DVS_W = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bemc_pkg::NUM_W-1:0] num,
	input  logic [DVS_W-1:0]           dvs,
	output logic                       done,
	output logic [bemc_pkg::NUM_W-1:0] quo
);
	import bemc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [NUM_W-1:0] quo_q;

	logic [DVS_W:0] rem_sh;
	logic [DVS_W:0] rem_nx;
	logic           fits;

	// restoring, one quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, quo_q[NUM_W-1]};
		fits   = rem_sh >= {1'b0, dvs_q};
		rem_nx = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			dvs_q <= dvs;
		end else if (busy_q) begin
			rem_q <= rem_nx[DVS_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> hdl/bemc_dp.sv
module bemc_dp #(
	parameter int PULSES_PER_REV = 360
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bemc_pkg::cmd_t   cmd,
	output bemc_pkg::sts_t   sts,
	input  bemc_pkg::cfg_t   cfg,
	input  logic [1:0]       mode,
	input  logic             b_level,
	input  logic [9:0]       sample,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [1:0]       kind,
	output logic [6:0]       data_one,
	output logic [6:0]       data_two,
	output logic [13:0]      bend,
	output logic [4:0]       channel,
	output logic             last
);
	import bemc_pkg::*;

	localparam int DEN_W   = $clog2(PULSES_PER_REV * 1023 + 1);
	localparam int DVS_W   = DEN_W + 1;
	localparam int DPROD_W = DEN_W + 10;

	// bow state
	logic signed [15:0] tick_q;
	logic [7:0]         right_run_q;
	logic [7:0]         left_run_q;
	logic [9:0]         elapsed_q;
	logic [1:0]         last_dir_q;
	logic               sounding_q;
	logic               out_valid_q;

	// per-item working registers
	logic [16:0]      mag_q;
	logic [9:0]       win_q;
	logic             change_q;
	logic             on_q;
	logic             snd_q;
	logic [9:0]       diff_q;
	logic [9:0]       span_q;
	logic [NUM_W-1:0] prod_q;
	logic [DEN_W-1:0] den_q;
	logic [9:0]       rpm_q;
	logic [6:0]       mapped_q;
	logic [13:0]      bend_q;

	// message register
	logic [1:0]  kind_q;
	logic [6:0]  data_one_q;
	logic [6:0]  data_two_q;
	logic [13:0] bend_out_q;
	logic [4:0]  channel_q;
	logic        last_q;

	logic [9:0]         win;
	logic [9:0]         scale;
	logic [9:0]         elapsed_inc;
	logic               win_hit;
	logic [1:0]         dir;
	logic               change;
	logic [16:0]        mag;
	logic [7:0]         rr_n;
	logic [7:0]         lr_n;
	logic [33:0]        mag_prod;
	logic [DPROD_W-1:0] den_prod;
	logic [16:0]        map_prod;

	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [DVS_W-1:0] div_dvs;
	logic             div_done;
	logic [NUM_W-1:0] quo;

	always_comb begin
		win         = (cfg.window_ms == '0) ? 10'd1 : cfg.window_ms;
		scale       = (cfg.max_rpm == '0) ? 10'd1 : cfg.max_rpm;
		elapsed_inc = elapsed_q + 10'd1;
		win_hit     = elapsed_inc >= win;
		if (tick_q > 16'sd0) begin
			dir = DIR_POS;
		end else if (tick_q < 16'sd0) begin
			dir = DIR_NEG;
		end else begin
			dir = DIR_STOP;
		end
		change = dir != last_dir_q;
		mag    = tick_q[15] ? (17'd0 - {1'b1, tick_q}) : {1'b0, tick_q};
		rr_n   = (right_run_q < cfg.run_threshold) ? (right_run_q + 8'd1) : right_run_q;
		lr_n   = (left_run_q < cfg.run_threshold) ? (left_run_q + 8'd1) : left_run_q;
	end

	assign mag_prod = 34'(mag_q) * 34'(RPM_K);
	assign den_prod = DPROD_W'(PULSES_PER_REV) * DPROD_W'(win_q);
	assign map_prod = 17'(rpm_q) * 17'(MAP_FULL);

	// divider operand select
	assign div_start = cmd.div_rpm | cmd.div_map | cmd.div_bend;
	always_comb begin
		if (cmd.div_rpm) begin
			div_num = prod_q + NUM_W'(den_q);
			div_dvs = {den_q, 1'b0};
		end else if (cmd.div_map) begin
			div_num = NUM_W'(map_prod);
			div_dvs = DVS_W'(scale);
		end else begin
			div_num = NUM_W'({diff_q, BEND_SHIFT'(0)});
			div_dvs = DVS_W'(span_q);
		end
	end

	bemc_div #(
		.DVS_W (DVS_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.dvs    (div_dvs),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			right_run_q <= '0;
			left_run_q  <= '0;
			elapsed_q   <= '0;
			last_dir_q  <= DIR_STOP;
			sounding_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				case (mode)
					MODE_EDGE: begin
						if (b_level) begin
							right_run_q <= rr_n;
							left_run_q  <= '0;
							if (rr_n >= cfg.run_threshold && tick_q != TICK_MAX) begin
								tick_q <= tick_q + 16'sd1;
							end
						end else begin
							left_run_q  <= lr_n;
							right_run_q <= '0;
							if (lr_n >= cfg.run_threshold && tick_q != TICK_MIN) begin
								tick_q <= tick_q - 16'sd1;
							end
						end
					end
					MODE_TICK: begin
						if (win_hit) begin
							elapsed_q  <= '0;
							tick_q     <= '0;
							last_dir_q <= dir;
							if (change) begin
								sounding_q <= dir != DIR_STOP;
							end
						end else begin
							elapsed_q <= elapsed_inc;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mag_q    <= mag;
			win_q    <= win;
			change_q <= change;
			on_q     <= change && (dir != DIR_STOP);
			snd_q    <= change ? (dir != DIR_STOP) : sounding_q;
			diff_q   <= sample - cfg.touch_threshold;
			span_q   <= ADC_FULL - cfg.touch_threshold;
		end
		if (cmd.mul) begin
			prod_q <= mag_prod[NUM_W-1:0];
			den_q  <= den_prod[DEN_W-1:0];
		end
		if (cmd.rpm_save) begin
			rpm_q <= (quo > NUM_W'(scale)) ? scale : quo[9:0];
		end
		if (cmd.map_save) begin
			mapped_q <= quo[6:0];
		end
		if (cmd.bend_save) begin
			bend_q <= quo[13:0];
		end
		if (cmd.emit) begin
			kind_q    <= cmd.emit_kind;
			channel_q <= cfg.midi_channel;
			last_q    <= cmd.emit_last;
			case (cmd.emit_kind)
				KIND_NOTE_OFF, KIND_NOTE_ON: begin
					data_one_q <= cfg.note_number;
					data_two_q <= cfg.note_velocity;
					bend_out_q <= '0;
				end
				KIND_CC: begin
					data_one_q <= cfg.controller_number;
					data_two_q <= mapped_q;
					bend_out_q <= '0;
				end
				default: begin
					data_one_q <= '0;
					data_two_q <= '0;
					bend_out_q <= bend_q;
				end
			endcase
		end
	end

	always_comb begin
		sts.win_end  = (mode == MODE_TICK) && win_hit;
		sts.touch    = (mode == MODE_TOUCH) && (sample > cfg.touch_threshold);
		sts.div_done = div_done;
		sts.change   = change_q;
		sts.note_on  = on_q;
		sts.cc_due   = (mapped_q != '0) && snd_q;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign data_one  = data_one_q;
	assign data_two  = data_two_q;
	assign bend      = bend_out_q;
	assign channel   = channel_q;
	assign last      = last_q;

endmodule

>>> hdl/bemc_ctrl.sv
module bemc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	output bemc_pkg::cmd_t cmd,
	input  bemc_pkg::sts_t sts
);
	import bemc_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_W_MUL  = 4'd1;
	localparam logic [3:0] ST_W_DIV  = 4'd2;
	localparam logic [3:0] ST_W_WAIT = 4'd3;
	localparam logic [3:0] ST_M_DIV  = 4'd4;
	localparam logic [3:0] ST_M_WAIT = 4'd5;
	localparam logic [3:0] ST_W_DEC  = 4'd6;
	localparam logic [3:0] ST_E_OFF  = 4'd7;
	localparam logic [3:0] ST_E_ON   = 4'd8;
	localparam logic [3:0] ST_E_CC   = 4'd9;
	localparam logic [3:0] ST_T_DIV  = 4'd10;
	localparam logic [3:0] ST_T_WAIT = 4'd11;
	localparam logic [3:0] ST_E_PB   = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		item_ready = state_q == ST_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.take = 1'b1;
					if (sts.win_end) begin
						state_d = ST_W_MUL;
					end else if (sts.touch) begin
						state_d = ST_T_DIV;
					end
				end
			end
			ST_W_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_W_DIV;
			end
			ST_W_DIV: begin
				cmd.div_rpm = 1'b1;
				state_d     = ST_W_WAIT;
			end
			ST_W_WAIT: begin
				if (sts.div_done) begin
					cmd.rpm_save = 1'b1;
					state_d      = ST_M_DIV;
				end
			end
			ST_M_DIV: begin
				cmd.div_map = 1'b1;
				state_d     = ST_M_WAIT;
			end
			ST_M_WAIT: begin
				if (sts.div_done) begin
					cmd.map_save = 1'b1;
					state_d      = ST_W_DEC;
				end
			end
			ST_W_DEC: begin
				if (sts.change) begin
					state_d = ST_E_OFF;
				end else if (sts.cc_due) begin
					state_d = ST_E_CC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_E_OFF: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_NOTE_OFF;
					cmd.emit_last = !sts.note_on && !sts.cc_due;
					if (sts.note_on) begin
						state_d = ST_E_ON;
					end else if (sts.cc_due) begin
						state_d = ST_E_CC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_E_ON: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_NOTE_ON;
					cmd.emit_last = !sts.cc_due;
					state_d       = sts.cc_due ? ST_E_CC : ST_IDLE;
				end
			end
			ST_E_CC: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_CC;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_T_DIV: begin
				cmd.div_bend = 1'b1;
				state_d      = ST_T_WAIT;
			end
			ST_T_WAIT: begin
				if (sts.div_done) begin
					cmd.bend_save = 1'b1;
					state_d       = ST_E_PB;
				end
			end
			ST_E_PB: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_BEND;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/bow_encoder_to_midi_controller.sv
// channel | dir | words                                   | handshake
// --------+-----+-----------------------------------------+-------------------------
// item    | in  | mode, b_level, sample                   | valid/ready
// msg     | out | kind, data_one, data_two, bend, channel,| valid/ready
//         |     | last                                    |
// apb     | in  | psel/penable/pwrite/paddr/pwdata/prdata | write at access phase
//
// Sequencing: encoder edges, non-final ticks, quiet touch samples and mode 3
// items are taken in idle and go no further. A touch bend and a window end run
// on the shared 32-step serial divider, used once for a bend and twice (rpm,
// then mapping) at a window end, and then emit any messages they produce.
// Reset: arst_n clears the bow state, the sequencer and the output valid;
// registers come back to their documented defaults.
// Stalls: msg.ready low holds the current word; the final word of an item may
// wait in the output register while the next item is taken.
module bow_encoder_to_midi_controller #(
	parameter int PULSES_PER_REV = 360
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bemc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	bemc_item_if.sink                   item,
	bemc_msg_if.source                  msg
);
	import bemc_pkg::*;

	cfg_t       cfg_q;
	cmd_t       cmd;
	sts_t       sts;
	logic       cfg_wr;
	logic [2:0] reg_idx;

	// register file, word-addressed; low address bits ignored
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_NOTE:  cfg_q.note_number       <= pwdata[6:0];
				REG_CTRL:  cfg_q.controller_number <= pwdata[6:0];
				REG_VEL:   cfg_q.note_velocity     <= pwdata[6:0];
				REG_CHAN:  cfg_q.midi_channel      <= pwdata[4:0];
				REG_WIN:   cfg_q.window_ms         <= pwdata[9:0];
				REG_RUN:   cfg_q.run_threshold     <= pwdata[7:0];
				REG_TOUCH: cfg_q.touch_threshold   <= pwdata[9:0];
				REG_MAX:   cfg_q.max_rpm           <= pwdata[9:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NOTE:  prdata = 32'(cfg_q.note_number);
			REG_CTRL:  prdata = 32'(cfg_q.controller_number);
			REG_VEL:   prdata = 32'(cfg_q.note_velocity);
			REG_CHAN:  prdata = 32'(cfg_q.midi_channel);
			REG_WIN:   prdata = 32'(cfg_q.window_ms);
			REG_RUN:   prdata = 32'(cfg_q.run_threshold);
			REG_TOUCH: prdata = 32'(cfg_q.touch_threshold);
			REG_MAX:   prdata = 32'(cfg_q.max_rpm);
			default:   prdata = '0;
		endcase
	end

	// sequencer: takes items, steps the divider, paces the messages
	bemc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// bow state, filter, rpm and bend math, output register
	bemc_dp #(
		.PULSES_PER_REV (PULSES_PER_REV)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg       (cfg_q),
		.mode      (item.mode),
		.b_level   (item.b_level),
		.sample    (item.sample),
		.out_ready (msg.ready),
		.out_valid (msg.valid),
		.kind      (msg.kind),
		.data_one  (msg.data_one),
		.data_two  (msg.data_two),
		.bend      (msg.bend),
		.channel   (msg.channel),
		.last      (msg.last)
	);

endmodule

>>> hdl/bemc_chk.sv
module bemc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic [1:0]  item_mode,
	input logic        msg_valid,
	input logic        msg_ready,
	input logic [1:0]  msg_kind,
	input logic [6:0]  msg_data_one,
	input logic [6:0]  msg_data_two,
	input logic [13:0] msg_bend,
	input logic [4:0]  msg_channel,
	input logic        msg_last
);
	import bemc_pkg::*;

	// stalled word holds
	a_msg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_ready |=> msg_valid &&
			$stable({msg_kind, msg_data_one, msg_data_two, msg_bend, msg_channel, msg_last}))
		else $error("msg word changed while stalled");

	// encoder edges never produce a message
	a_edge_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_mode == MODE_EDGE |=> !$rose(msg_valid))
		else $error("message after encoder edge");

	// a bend is a single, final word within full scale
	a_bend_last: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_kind == KIND_BEND |-> msg_last && msg_bend <= 14'd8192)
		else $error("bad pitch bend word");

	// only bends carry a bend value
	a_bend_zero: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_kind != KIND_BEND |-> msg_bend == '0)
		else $error("bend set on non-bend word");

endmodule

bind bow_encoder_to_midi_controller bemc_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_mode    (item.mode),
	.msg_valid    (msg.valid),
	.msg_ready    (msg.ready),
	.msg_kind     (msg.kind),
	.msg_data_one (msg.data_one),
	.msg_data_two (msg.data_two),
	.msg_bend     (msg.bend),
	.msg_channel  (msg.channel),
	.msg_last     (msg.last)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps

// Bench for bow_encoder_to_midi_controller.
// Items go in on item_bus and MIDI words come out on msg_bus. An in-bench
// model of the bow filter, the speed window and the touch strip predicts
// every word but where a table row gives a hand-written expectation. A word
// taken from msg_bus is checked field by field against the oldest expected one.
module testbench;
	import bemc_pkg::*;

	localparam int PULSES       = 360;
	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE       = 150;   // room for a window end and its words
	localparam int WORDS_PER_MIX = 53;
	localparam int HOLD_CYCLES  = 300;

	localparam logic [1:0] MODE_SPARE = 2'd3;   // unused mode, block drops it

	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  data_one;
		logic [6:0]  data_two;
		logic [13:0] bend;
		logic [4:0]  channel;
		logic        last;
	} msg_t;

	// one stimulus line: a register write or an input word, with an
	// optional hand-written expectation (typed = 1)
	typedef struct packed {
		logic        is_cfg;
		logic [2:0]  ridx;
		logic [31:0] wval;
		logic [1:0]  mode;
		logic        b_level;
		logic [9:0]  sample;
		logic        typed;
		logic        typ_cnt;
		msg_t        typ;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bemc_item_if item_bus ();
	bemc_msg_if  msg_bus ();

	bow_encoder_to_midi_controller #(
		.PULSES_PER_REV(PULSES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_bus),
		.msg     (msg_bus)
	);

	// ---------------------------------------------------------------
	// bow model: registers and state as the block should hold them
	// ---------------------------------------------------------------
	cfg_t       regs_now    = CFG_RESET;
	int         bow_ticks   = 0;      // signed tick count, +-32k saturating
	logic [7:0] right_len   = '0;     // same-direction run lengths
	logic [7:0] left_len    = '0;
	logic [9:0] ms_elapsed  = '0;
	logic [1:0] bow_dir     = DIR_STOP;
	bit         note_held   = 0;

	msg_t midi_due [$];   // predicted words, oldest first

	int fails      = 0;
	int words_in   = 0;
	int reg_writes = 0;
	int cycles     = 0;
	int kinds_seen [4] = '{default: 0};
	bit unsettled  = 0;   // a word went in since the last drain

	// idle mix, in percent per cycle
	int snd_idle = 0;
	int rcv_idle = 0;

	// long receiver hold: main process bumps hold_req_id, receiver runs it
	int hold_req_id = 0;
	int hold_seen   = 0;
	int hold_left   = 0;

	// ---------------------------------------------------------------
	// clock, cycle limit
	// ---------------------------------------------------------------
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d words still expected", $time, midi_due.size());
			$display("[bow_encoder_to_midi_controller] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// predictor: expected MIDI words for one input word
	// ---------------------------------------------------------------
	function automatic void midi_for_item(input logic [1:0] mode, input logic b,
		input logic [9:0] sample, output msg_t res [3], output int n);
		longint unsigned mag, den, rpm;
		int unsigned     win, scale, mapped, bend;
		logic [1:0]      dir;
		n = 0;
		res = '{default: '0};
		case (mode)
			MODE_EDGE: begin
				// run filter: only a long enough run moves the count
				if (b) begin
					if (right_len < regs_now.run_threshold) right_len++;
					left_len = '0;
					if (right_len >= regs_now.run_threshold && bow_ticks < 32767)
						bow_ticks++;
				end else begin
					if (left_len < regs_now.run_threshold) left_len++;
					right_len = '0;
					if (left_len >= regs_now.run_threshold && bow_ticks > -32768)
						bow_ticks--;
				end
			end
			MODE_TICK: begin
				// zero window and zero full scale both act as one
				win   = (regs_now.window_ms == '0) ? 1 : regs_now.window_ms;
				scale = (regs_now.max_rpm == '0) ? 1 : regs_now.max_rpm;
				ms_elapsed++;
				if (ms_elapsed >= win) begin
					mag = (bow_ticks < 0) ? -bow_ticks : bow_ticks;
					den = PULSES * win;
					rpm = (2 * mag * 60000 + den) / (2 * den);   // round half up
					if (rpm > scale) rpm = scale;
					mapped = int'(rpm * 127 / scale);
					dir = (bow_ticks > 0) ? DIR_POS : ((bow_ticks < 0) ? DIR_NEG : DIR_STOP);
					if (dir != bow_dir) begin
						res[n] = '{KIND_NOTE_OFF, regs_now.note_number, regs_now.note_velocity,
							14'd0, regs_now.midi_channel, 1'b0};
						n++;
						if (dir != DIR_STOP) begin
							res[n] = '{KIND_NOTE_ON, regs_now.note_number,
								regs_now.note_velocity, 14'd0, regs_now.midi_channel, 1'b0};
							n++;
							note_held = 1;
						end else begin
							note_held = 0;
						end
					end
					if (mapped != 0 && note_held) begin
						res[n] = '{KIND_CC, regs_now.controller_number, mapped[6:0], 14'd0,
							regs_now.midi_channel, 1'b0};
						n++;
					end
					bow_ticks  = 0;
					ms_elapsed = '0;
					bow_dir    = dir;
				end
			end
			MODE_TOUCH: begin
				if (sample > regs_now.touch_threshold) begin
					bend = (int'(sample) - int'(regs_now.touch_threshold)) * 8192
						/ (1023 - int'(regs_now.touch_threshold));
					res[n] = '{KIND_BEND, 7'd0, 7'd0, bend[13:0], regs_now.midi_channel, 1'b0};
					n++;
				end
			end
			default: ;
		endcase
		if (n > 0) res[n-1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// output side: ready pattern and checker
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_left > 0) begin
			msg_bus.ready <= 1'b0;
			hold_left--;
		end else if (hold_seen != hold_req_id) begin
			hold_seen = hold_req_id;
			hold_left = HOLD_CYCLES - 1;
			msg_bus.ready <= 1'b0;
		end else begin
			msg_bus.ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	function automatic void check_field(string name, logic [13:0] want, logic [13:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : msg_check
		msg_t got, want;
		if (arst_n && msg_bus.valid && msg_bus.ready) begin
			got = '{msg_bus.kind, msg_bus.data_one, msg_bus.data_two, msg_bus.bend,
				msg_bus.channel, msg_bus.last};
			kinds_seen[got.kind]++;
			if (midi_due.size() == 0) begin
				fails++;
				$display("%0t: word with none expected, kind %0d d1 %0d d2 %0d bend %0d",
					$time, got.kind, got.data_one, got.data_two, got.bend);
			end else begin
				want = midi_due.pop_front();
				check_field("kind", want.kind, got.kind);
				check_field("data_one", want.data_one, got.data_one);
				check_field("data_two", want.data_two, got.data_two);
				check_field("bend", want.bend, got.bend);
				check_field("channel", want.channel, got.channel);
				check_field("last", want.last, got.last);
			end
		end
	end

	// ---------------------------------------------------------------
	// input side
	// ---------------------------------------------------------------
	// offer one word; valid stays up so back-to-back words need no gap
	task automatic offer_word(input logic [1:0] mode, input logic b, input logic [9:0] sample,
		input bit typed, input bit typ_cnt, input msg_t typ);
		msg_t res [3];
		int   n;
		while ($urandom_range(99) < snd_idle) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid   <= 1'b1;
		item_bus.mode    <= mode;
		item_bus.b_level <= b;
		item_bus.sample  <= sample;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		midi_for_item(mode, b, sample, res, n);
		if (typed) begin
			if (typ_cnt) midi_due.push_back(typ);
		end else begin
			for (int i = 0; i < n; i++) midi_due.push_back(res[i]);
		end
		if (mode != MODE_SPARE) words_in++;
		unsettled = 1;
	endtask

	task automatic send(input logic [1:0] mode, input logic b, input logic [9:0] sample);
		offer_word(mode, b, sample, 1'b0, 1'b0, '0);
	endtask

	// drop valid, let every predicted word come out, then let the block go idle
	task automatic wait_quiet();
		item_bus.valid <= 1'b0;
		while (midi_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		unsettled = 0;
	endtask

	// ---------------------------------------------------------------
	// register port
	// ---------------------------------------------------------------
	task automatic apb_cycle(input logic [2:0] idx, input bit wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_readback(input logic [2:0] idx, input logic [31:0] want);
		logic [31:0] rd;
		apb_cycle(idx, 1'b0, '0, rd);
		if (rd !== want) begin
			fails++;
			$display("%0t: reg %0d readback, expected %0d, got %0d", $time, idx, want, rd);
		end
	endtask

	// write, mirror into the model (masked to width), read back
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] keep, rd;
		if (unsettled) wait_quiet();
		case (idx)
			REG_NOTE: begin
				keep = val & 32'h7F;
				regs_now.note_number = keep[6:0];
			end
			REG_CTRL: begin
				keep = val & 32'h7F;
				regs_now.controller_number = keep[6:0];
			end
			REG_VEL: begin
				keep = val & 32'h7F;
				regs_now.note_velocity = keep[6:0];
			end
			REG_CHAN: begin
				keep = val & 32'h1F;
				regs_now.midi_channel = keep[4:0];
			end
			REG_WIN: begin
				keep = val & 32'h3FF;
				regs_now.window_ms = keep[9:0];
			end
			REG_RUN: begin
				keep = val & 32'hFF;
				regs_now.run_threshold = keep[7:0];
			end
			REG_TOUCH: begin
				keep = val & 32'h3FF;
				regs_now.touch_threshold = keep[9:0];
			end
			default: begin
				keep = val & 32'h3FF;
				regs_now.max_rpm = keep[9:0];
			end
		endcase
		apb_cycle(idx, 1'b1, val, rd);
		reg_writes++;
		reg_readback(idx, keep);
	endtask

	// low or high end a fifth of the time each, else anything in range
	function automatic int unsigned span_pick(int unsigned lo, int unsigned hi);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 20) return lo;
		if (r < 40) return hi;
		return $urandom_range(hi, lo);
	endfunction

	task automatic pick_settings();
		int unsigned r;
		write_reg(REG_NOTE, span_pick(0, 127));
		write_reg(REG_CTRL, span_pick(0, 127));
		write_reg(REG_VEL, span_pick(0, 127));
		write_reg(REG_CHAN, span_pick(1, 16));
		// short windows mostly, so strokes end in a window end
		r = $urandom_range(99);
		write_reg(REG_WIN, (r < 12) ? 0 : (r < 20) ? 1023 : (r < 25) ? 1000 : $urandom_range(6, 1));
		r = $urandom_range(99);
		write_reg(REG_RUN, (r < 15) ? 0 : (r < 22) ? 255 : $urandom_range(4, 1));
		write_reg(REG_TOUCH, span_pick(0, 1022));
		r = $urandom_range(99);
		write_reg(REG_MAX, (r < 12) ? 0 : span_pick(1, 1023));
	endtask

	// a bow stroke: a run of edges with some noise and touches, then ticks
	task automatic bow_stroke();
		logic        dir;
		int unsigned lim, len, win, nt;
		dir = 1'($urandom_range(1));
		lim = regs_now.run_threshold + 6;
		if (lim > 24) lim = 24;
		len = $urandom_range(lim);
		for (int e = 0; e < len; e++) begin
			if ($urandom_range(99) < 8)
				send(MODE_TOUCH, 1'($urandom_range(1)), 10'($urandom_range(1023)));
			send(MODE_EDGE, ($urandom_range(99) < 8) ? !dir : dir, 10'($urandom_range(1023)));
		end
		win = (regs_now.window_ms == '0) ? 1 : regs_now.window_ms;
		nt  = (win <= 8) ? $urandom_range(win + 1, 1) : $urandom_range(8, 1);
		for (int t = 0; t < nt; t++)
			send(MODE_TICK, 1'($urandom_range(1)), 10'($urandom_range(1023)));
	endtask

	// ---------------------------------------------------------------
	// directed table
	// ---------------------------------------------------------------
	function automatic row_t reg_row(input logic [2:0] idx, input logic [31:0] v);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.ridx   = idx;
		r.wval   = v;
		return r;
	endfunction

	function automatic row_t word_row(input logic [1:0] mode, input logic b, input logic [9:0] s);
		row_t r;
		r = '0;
		r.mode    = mode;
		r.b_level = b;
		r.sample  = s;
		return r;
	endfunction

	// word that must produce nothing
	function automatic row_t quiet_row(input logic [1:0] mode, input logic b, input logic [9:0] s);
		row_t r;
		r = word_row(mode, b, s);
		r.typed = 1'b1;
		return r;
	endfunction

	function automatic row_t bend_row(input logic [9:0] s, input logic [13:0] bend,
		input logic [4:0] ch);
		row_t r;
		r = word_row(MODE_TOUCH, 1'b0, s);
		r.typed   = 1'b1;
		r.typ_cnt = 1'b1;
		r.typ     = '{KIND_BEND, 7'd0, 7'd0, bend, ch, 1'b1};
		return r;
	endfunction

	row_t plan [$];

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin : stimulus
		int target;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		item_bus.valid   = 1'b0;
		item_bus.mode    = MODE_EDGE;
		item_bus.b_level = 1'b0;
		item_bus.sample  = '0;
		msg_bus.ready    = 1'b0;

		plan = '{
			// reset settings: touch threshold 25, channel 1
			bend_row(10'd1023, 14'd8192, 5'd1),          // full-scale touch
			quiet_row(MODE_TOUCH, 1'b0, 10'd0),
			quiet_row(MODE_TOUCH, 1'b0, 10'd25),         // exactly at threshold
			word_row(MODE_TOUCH, 1'b1, 10'd26),          // one above
			quiet_row(MODE_SPARE, 1'b1, 10'd1023),       // unused mode
			quiet_row(MODE_SPARE, 1'b0, 10'd0),
			quiet_row(MODE_EDGE, 1'b1, 10'd0),           // run of 1 of 10
			quiet_row(MODE_TICK, 1'b0, 10'd0),           // 1 ms of 100
			// zero window, zero run threshold, zero full scale
			reg_row(REG_WIN, 32'd0),
			reg_row(REG_RUN, 32'd0),
			reg_row(REG_MAX, 32'd0),
			reg_row(REG_NOTE, 32'd127),
			reg_row(REG_CTRL, 32'd0),
			reg_row(REG_VEL, 32'd0),
			reg_row(REG_CHAN, 32'd16),
			word_row(MODE_EDGE, 1'b1, 10'd0),            // counts at once
			word_row(MODE_TICK, 1'b0, 10'd0),            // off, on, cc
			word_row(MODE_TICK, 1'b0, 10'd0),            // stopped: off only
			word_row(MODE_EDGE, 1'b0, 10'd1023),
			word_row(MODE_EDGE, 1'b0, 10'd512),
			word_row(MODE_TICK, 1'b1, 10'd1023),         // reverse stroke
			// touch threshold extremes, masked register writes
			reg_row(REG_TOUCH, 32'd1022),
			reg_row(REG_CHAN, 32'hFFFF_FFE0),            // masks to 0
			bend_row(10'd1023, 14'd8192, 5'd0),
			quiet_row(MODE_TOUCH, 1'b1, 10'd1022),
			reg_row(REG_TOUCH, 32'h0000_FFFF),           // masks to 1023
			quiet_row(MODE_TOUCH, 1'b0, 10'd1023),
			reg_row(REG_TOUCH, 32'd0),
			word_row(MODE_TOUCH, 1'b0, 10'd1),
			quiet_row(MODE_TOUCH, 1'b0, 10'd0),
			// run threshold at max, full scale at max
			reg_row(REG_RUN, 32'd255),
			reg_row(REG_MAX, 32'd1023),
			reg_row(REG_NOTE, 32'd0),
			reg_row(REG_CTRL, 32'd127),
			reg_row(REG_VEL, 32'd127),
			reg_row(REG_CHAN, 32'd1),
			word_row(MODE_EDGE, 1'b1, 10'd0),
			word_row(MODE_TICK, 1'b0, 10'd0),            // filtered out: stop
			reg_row(REG_RUN, 32'd2),
			word_row(MODE_EDGE, 1'b1, 10'd0),
			word_row(MODE_EDGE, 1'b0, 10'd0),            // noise edge clears the run
			word_row(MODE_EDGE, 1'b0, 10'd0),
			word_row(MODE_EDGE, 1'b0, 10'd0),
			word_row(MODE_TICK, 1'b0, 10'd0)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers come up at their defaults
		reg_readback(REG_NOTE, 32'(CFG_RESET.note_number));
		reg_readback(REG_CTRL, 32'(CFG_RESET.controller_number));
		reg_readback(REG_VEL, 32'(CFG_RESET.note_velocity));
		reg_readback(REG_CHAN, 32'(CFG_RESET.midi_channel));
		reg_readback(REG_WIN, 32'(CFG_RESET.window_ms));
		reg_readback(REG_RUN, 32'(CFG_RESET.run_threshold));
		reg_readback(REG_TOUCH, 32'(CFG_RESET.touch_threshold));
		reg_readback(REG_MAX, 32'(CFG_RESET.max_rpm));

		snd_idle = 21;
		rcv_idle = 81;
		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].ridx, plan[i].wval);
			else
				offer_word(plan[i].mode, plan[i].b_level, plan[i].sample,
					plan[i].typed, plan[i].typ_cnt, plan[i].typ);
		end

		// random part: two settings per idle mix
		for (int s = 0; s < 6; s++) begin
			case (s / 2)
				0: begin
					snd_idle = 21;
					rcv_idle = 81;
				end
				1: begin
					snd_idle = 81;
					rcv_idle = 21;
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
				end
			endcase
			pick_settings();
			if (s == 4) begin
				// receiver stalls for a long stretch while touches keep coming,
				// so the output backs up into the input; then drain fully
				hold_req_id++;
				for (int k = 0; k < 12; k++)
					send(MODE_TOUCH, 1'($urandom_range(1)),
						10'($urandom_range(1023, regs_now.touch_threshold + 1)));
				wait_quiet();
			end
			target = words_in + WORDS_PER_MIX;
			while (words_in < target) begin
				case ($urandom_range(99)) inside
					[0:69]:  bow_stroke();
					[70:84]: send(MODE_TOUCH, 1'($urandom_range(1)),
						10'($urandom_range(1023)));
					[85:91]: send(MODE_SPARE, 1'($urandom_range(1)),
						10'($urandom_range(1023)));
					default: send(2'($urandom_range(1)), 1'($urandom_range(1)),
						10'($urandom_range(1023)));
				endcase
			end
		end

		wait_quiet();

		$display("covered %0d input words and %0d register writes over three idle mixes,",
			words_in, reg_writes);
		$display("with a long output stall; seen %0d off, %0d on, %0d cc, %0d bend",
			kinds_seen[KIND_NOTE_OFF], kinds_seen[KIND_NOTE_ON], kinds_seen[KIND_CC],
			kinds_seen[KIND_BEND]);
		if (fails == 0) begin
			$display("[bow_encoder_to_midi_controller] OK");
		end else begin
			$display("[bow_encoder_to_midi_controller] ERROR");
		end
		$finish;
	end

endmodule
